// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the utf-8 to utf-16 decoder: beat structs,
// error codes and the operation record passed from front to back.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // code point limits
  localparam logic [20:0] SuppBase = 21'h01_0000;
  localparam logic [20:0] MaxCode  = 21'h10_FFFF;

  // surrogate tag bits, the upper six bits of each surrogate unit
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  // error codes reported with a result
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ENDING  = 2'd1,
    ERR_TRAIL   = 2'd2,
    ERR_UNICODE = 2'd3
  } err_code_e;

  // what the back end has to do for one queued entry
  typedef enum logic [1:0] {
    OP_UNIT  = 2'd0,
    OP_PAIR  = 2'd1,
    OP_ERROR = 2'd2
  } op_kind_e;

  // input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [15:0] code_unit;
    err_code_e   error_code;
    logic        last_of_run;
  } out_beat_t;

  // queued operation
  typedef struct packed {
    op_kind_e    kind;
    logic [20:0] code;
    err_code_e   err;
  } op_t;

  // queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ===== sv/u8u16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: tracks pending continuation bytes, gathers the code point,
// and turns each finished sequence or error into one queued operation.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8u16_pkg::in_beat_t in_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output u8u16_pkg::op_t      op_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic        disc_q, disc_d;

  logic                  in_fire;
  logic [7:0]            b;
  logic                  eos;
  logic                  fail_set;
  u8u16_pkg::err_code_e  fail_err;
  logic                  emit_set;
  logic [20:0]           emit_code;
  logic [1:0]            pend_new;
  logic [20:0]           acc_new;
  logic [20:0]           trail_bits;

  // one beat per cycle as long as the queue has room
  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = in_data_i.in_byte;
  assign eos        = in_data_i.end_of_string;

  // place the six payload bits of a continuation byte
  assign pend_new = 2'(pend_q - 2'd1);
  always_comb begin
    unique case (pend_new)
      2'd0:    trail_bits = {15'd0, b[5:0]};
      2'd1:    trail_bits = {9'd0, b[5:0], 6'd0};
      2'd2:    trail_bits = {3'd0, b[5:0], 12'd0};
      default: trail_bits = '0;
    endcase
  end
  assign acc_new = acc_q | trail_bits;

  // decode step
  always_comb begin
    pend_d    = pend_q;
    acc_d     = acc_q;
    disc_d    = disc_q;
    fail_set  = 1'b0;
    fail_err  = u8u16_pkg::ERR_NONE;
    emit_set  = 1'b0;
    emit_code = '0;
    push_o    = 1'b0;
    op_o      = '{kind: u8u16_pkg::OP_UNIT, code: '0, err: u8u16_pkg::ERR_NONE};

    if (in_fire) begin
      if (disc_q) begin
        // drop bytes until the string ends
        if (eos) disc_d = 1'b0;
      end else if (pend_q == 2'd0) begin
        // lead byte
        priority if (!b[7]) begin
          emit_set  = 1'b1;
          emit_code = {13'd0, b};
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {b[2:0], 18'd0};
          pend_d = 2'd3;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {5'd0, b[3:0], 12'd0};
          pend_d = 2'd2;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {10'd0, b[4:0], 6'd0};
          pend_d = 2'd1;
        end else begin
          fail_set = 1'b1;
          fail_err = u8u16_pkg::ERR_UNICODE;
        end
        if (b[7] && !fail_set && eos) begin
          fail_set = 1'b1;
          fail_err = u8u16_pkg::ERR_ENDING;
        end
      end else begin
        // continuation byte
        if (b[7:6] != 2'b10) begin
          fail_set = 1'b1;
          fail_err = u8u16_pkg::ERR_TRAIL;
        end else begin
          pend_d = pend_new;
          acc_d  = acc_new;
          if (pend_new == 2'd0) begin
            emit_set  = 1'b1;
            emit_code = acc_new;
          end else if (eos) begin
            fail_set = 1'b1;
            fail_err = u8u16_pkg::ERR_ENDING;
          end
        end
      end

      // finished code point: one unit, a surrogate pair, or out of range
      if (emit_set) begin
        pend_d = 2'd0;
        acc_d  = '0;
        push_o = 1'b1;
        if (emit_code < u8u16_pkg::SuppBase) begin
          op_o.kind = u8u16_pkg::OP_UNIT;
          op_o.code = emit_code;
        end else if (emit_code <= u8u16_pkg::MaxCode) begin
          op_o.kind = u8u16_pkg::OP_PAIR;
          op_o.code = emit_code;
        end else begin
          fail_set = 1'b1;
          fail_err = u8u16_pkg::ERR_UNICODE;
        end
      end

      // error: report once, then drop the rest of the string
      if (fail_set) begin
        pend_d    = 2'd0;
        acc_d     = '0;
        disc_d    = !eos;
        push_o    = 1'b1;
        op_o.kind = u8u16_pkg::OP_ERROR;
        op_o.code = '0;
        op_o.err  = fail_err;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      acc_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      disc_q <= disc_d;
    end
  end

`ifndef SYNTHESIS
  // a string end leaves the decoder clean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && eos |=> pend_q == 2'd0 && acc_q == '0 && !disc_q)
    else $error("front state not clear after end of string");

  // while dropping bytes nothing is being gathered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> pend_q == 2'd0 && acc_q == '0)
    else $error("front gathering while discarding");

  // with no sequence open the accumulator is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> acc_q == '0)
    else $error("stale accumulator with no sequence open");
`endif

endmodule

// ===== sv/u8u16_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short queue of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
  parameter int unsigned Depth = u8u16_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u8u16_pkg::op_t        wdata_i,
  input  logic                  pop_i,
  output u8u16_pkg::op_t        rdata_o,
  output u8u16_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8u16_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full      = (cnt_q == FullCnt);
  assign status_o.not_empty = (cnt_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : PtrW'(wptr_q + 1'b1);
      if (do_pop)  rptr_q <= (rptr_q == LastPtr) ? '0 : PtrW'(rptr_q + 1'b1);
      if (do_push && !do_pop)      cnt_q <= CntW'(cnt_q + 1'b1);
      else if (do_pop && !do_push) cnt_q <= CntW'(cnt_q - 1'b1);
    end
  end

endmodule

// ===== sv/u8u16_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Result stage: turns each queued operation into one or two output beats,
// splitting supplementary code points into a surrogate pair.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u8u16_pkg::q_status_t q_status_i,
  input  u8u16_pkg::op_t       op_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_beat_t out_data_o
);

  logic                 out_valid_q, out_valid_d;
  u8u16_pkg::out_beat_t out_data_q, out_data_d;
  logic                 low_pend_q, low_pend_d;
  logic [9:0]           low_q, low_d;

  logic        can_load;
  logic [10:0] hi_sub;

  assign can_load = !out_valid_q || out_ready_i;
  assign pop_o    = can_load && !low_pend_q && q_status_i.not_empty;

  // upper ten bits of (code - 0x10000)
  assign hi_sub = 11'(op_i.code[20:10] - u8u16_pkg::SuppBase[20:10]);

  // load the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    low_pend_d  = low_pend_q;
    low_d       = low_q;
    if (can_load) begin
      if (low_pend_q) begin
        out_valid_d = 1'b1;
        out_data_d  = '{code_unit: {u8u16_pkg::LowSurrTag, low_q},
                        error_code: u8u16_pkg::ERR_NONE, last_of_run: 1'b1};
        low_pend_d  = 1'b0;
      end else if (q_status_i.not_empty) begin
        out_valid_d = 1'b1;
        unique case (op_i.kind)
          u8u16_pkg::OP_UNIT: begin
            out_data_d = '{code_unit: op_i.code[15:0],
                           error_code: u8u16_pkg::ERR_NONE, last_of_run: 1'b1};
          end
          u8u16_pkg::OP_PAIR: begin
            out_data_d = '{code_unit: {u8u16_pkg::HighSurrTag, hi_sub[9:0]},
                           error_code: u8u16_pkg::ERR_NONE, last_of_run: 1'b0};
            low_pend_d = 1'b1;
            low_d      = op_i.code[9:0];
          end
          default: begin
            out_data_d = '{code_unit: '0, error_code: op_i.err, last_of_run: 1'b1};
          end
        endcase
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      low_pend_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      low_pend_q  <= low_pend_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    low_q      <= low_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a waiting low surrogate sits behind a high surrogate in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_pend_q |-> out_valid_q && !out_data_q.last_of_run)
    else $error("low surrogate pending without its high half");

  // the low half follows its high half with no gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !out_data_q.last_of_run |=>
      out_valid_q && out_data_q.last_of_run)
    else $error("surrogate pair broken");

  // error beats carry a zero unit and close the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.error_code != u8u16_pkg::ERR_NONE |->
      out_data_q.code_unit == '0 && out_data_q.last_of_run)
    else $error("malformed error beat");
`endif

endmodule

// ===== sv/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming utf-8 to utf-16 converter: one byte per input beat, one utf-16
// code unit (or error report) per output beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_data_i  (in_byte, end_of_string)
//  out     | out | out_valid_o/out_ready_i | out_data_o (code_unit, error_code,
//          |     |                        |             last_of_run)
//
// The front decodes one byte per cycle while the queue has room; its state update is the only loop.
// A result passes through the queue and then the output register before it is offered.
// The back emits one beat per cycle while the output is ready; a surrogate pair takes two
// of them, so a stream of four-byte sequences is limited by the input side only.
// Reset clears decoder state, queue and output register; no clearing pass.
// Either side may stall on its own: the queue absorbs QueueDepth operations.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
  parameter int unsigned QueueDepth = u8u16_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u8u16_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_beat_t out_data_o
);

  u8u16_pkg::q_status_t q_status;
  u8u16_pkg::op_t       push_op;
  u8u16_pkg::op_t       pop_op;
  logic                 push;
  logic                 pop;

  // byte decoder
  u8u16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // operation queue
  u8u16_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_op),
    .pop_i    (pop),
    .rdata_o  (pop_op),
    .status_o (q_status)
  );

  // result stage
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .op_i        (pop_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/utf8_to_utf16_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_tb
// Self-checking bench for the utf-8 to utf-16 decoder. A behavioral copy of the
// decoder turns every accepted input byte into the utf-16 units or error
// reports it must cause. Each output beat is checked in order against them.
// The stimulus is a directed set of corner cases, then random strings: mostly
// well-formed text with some damage, and some raw noise. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_tb;

  // behavioral decoder and store of the units still awaited at the output
  class utf16_units;
    logic [1:0]           need;        // continuation bytes still due
    logic [20:0]          acc;         // code point gathered so far
    logic                 skip;        // dropping bytes up to end of string
    u8u16_pkg::out_beat_t awaited_units[$];
    int unsigned          mismatches;

    function new();
      need = '0;
      acc = '0;
      skip = 1'b0;
      mismatches = 0;
    endfunction

    function void push_unit(logic [15:0] unit, u8u16_pkg::err_code_e err, logic last);
      u8u16_pkg::out_beat_t beat;
      beat.code_unit = unit;
      beat.error_code = err;
      beat.last_of_run = last;
      awaited_units.insert(awaited_units.size(), beat);
    endfunction

    // error report clears the sequence, drops the rest unless the string ends
    function void raise_error(u8u16_pkg::err_code_e err, logic eos);
      need = '0;
      acc = '0;
      skip = !eos;
      push_unit(16'h0000, err, 1'b1);
    endfunction

    // one unit, a surrogate pair, or an out-of-range error
    function void finish_code(logic [20:0] code, logic eos);
      logic [20:0] offs;
      need = '0;
      acc = '0;
      if (code < u8u16_pkg::SuppBase) begin
        push_unit(code[15:0], u8u16_pkg::ERR_NONE, 1'b1);
      end else if (code <= u8u16_pkg::MaxCode) begin
        offs = code - u8u16_pkg::SuppBase;
        push_unit({u8u16_pkg::HighSurrTag, offs[19:10]}, u8u16_pkg::ERR_NONE, 1'b0);
        push_unit({u8u16_pkg::LowSurrTag, offs[9:0]}, u8u16_pkg::ERR_NONE, 1'b1);
      end else begin
        raise_error(u8u16_pkg::ERR_UNICODE, eos);
      end
    endfunction

    function void note_byte(u8u16_pkg::in_beat_t beat);
      logic [7:0] b;
      logic       eos;
      b = beat.in_byte;
      eos = beat.end_of_string;
      if (skip) begin
        if (eos) skip = 1'b0;
        return;
      end
      // lead byte
      if (need == 2'd0) begin
        if (!b[7]) begin
          finish_code({13'd0, b}, eos);
          return;
        end
        if (b[7:3] == 5'b11110) begin
          acc = {b[2:0], 18'd0};
          need = 2'd3;
        end else if (b[7:4] == 4'b1110) begin
          acc = {5'd0, b[3:0], 12'd0};
          need = 2'd2;
        end else if (b[7:5] == 3'b110) begin
          acc = {10'd0, b[4:0], 6'd0};
          need = 2'd1;
        end else begin
          raise_error(u8u16_pkg::ERR_UNICODE, eos);
          return;
        end
        if (eos) raise_error(u8u16_pkg::ERR_ENDING, eos);
        return;
      end
      // continuation byte; a bad one wins over the end flag
      if (b[7:6] != 2'b10) begin
        raise_error(u8u16_pkg::ERR_TRAIL, eos);
        return;
      end
      need = need - 2'd1;
      acc = acc | ({15'd0, b[5:0]} << (6 * need));
      if (need == 2'd0) finish_code(acc, eos);
      else if (eos) raise_error(u8u16_pkg::ERR_ENDING, eos);
    endfunction

    function void report(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    endfunction

    function void check_unit(u8u16_pkg::out_beat_t got);
      u8u16_pkg::out_beat_t want;
      if (awaited_units.size() == 0) begin
        mismatches++;
        $display("%0t: beat expected none got unit %h error %0d last %b", $time,
                 got.code_unit, got.error_code, got.last_of_run);
        return;
      end
      want = awaited_units.pop_front();
      if (got.code_unit !== want.code_unit)
        report("code_unit", want.code_unit, got.code_unit);
      if (got.error_code !== want.error_code)
        report("error_code", 16'(want.error_code), 16'(got.error_code));
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction

    function int unsigned outstanding();
      return awaited_units.size();
    endfunction

    function void flag_leftovers();
      if (awaited_units.size() != 0) begin
        mismatches += awaited_units.size();
        $display("%0t: %0d units expected but never seen", $time,
                 awaited_units.size());
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  u8u16_pkg::in_beat_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  u8u16_pkg::out_beat_t out_data_o;

  utf16_units  units = new();
  logic        calm = 1'b0;    // no idling on either side while set
  int unsigned beats_sent = 0;

  utf8_to_utf16_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: check each accepted beat, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) units.check_unit(out_data_o);
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  // offer one byte, idling first at random, and wait for the handshake
  task automatic send_beat(logic [7:0] b, logic eos);
    u8u16_pkg::in_beat_t beat;
    beat.in_byte = b;
    beat.end_of_string = eos;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    units.note_byte(beat);
    beats_sent++;
  endtask

  // sender holds off until every awaited unit has come out
  task automatic drain_output();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (units.outstanding() != 0);
  endtask

  function automatic void add_utf8(ref logic [7:0] text[$], input logic [20:0] cp,
                                   input int unsigned len);
    case (len)
      1: text.insert(text.size(), {1'b0, cp[6:0]});
      2: begin
        text.insert(text.size(), {3'b110, cp[10:6]});
        text.insert(text.size(), {2'b10, cp[5:0]});
      end
      3: begin
        text.insert(text.size(), {4'b1110, cp[15:12]});
        text.insert(text.size(), {2'b10, cp[11:6]});
        text.insert(text.size(), {2'b10, cp[5:0]});
      end
      default: begin
        text.insert(text.size(), {5'b11110, cp[20:18]});
        text.insert(text.size(), {2'b10, cp[17:12]});
        text.insert(text.size(), {2'b10, cp[11:6]});
        text.insert(text.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // one random string: mostly valid text, some damaged, some raw noise
  task automatic send_random_string();
    logic [7:0]  text[$];
    logic [20:0] cp;
    int unsigned pick, len, pos;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = $urandom_range(1, 6);
      repeat (len) text.insert(text.size(), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        len = $urandom_range(1, 4);
        case (len)
          1: cp = 21'($urandom_range(0, 'h7F));
          2: cp = 21'($urandom_range(0, 'h7FF));
          3: cp = 21'($urandom_range(0, 'hFFFF));
          default: begin
            if ($urandom_range(0, 9) == 0) cp = 21'($urandom_range(0, 'h1F_FFFF));
            else cp = 21'($urandom_range('h1_0000, 'h10_FFFF));
          end
        endcase
        add_utf8(text, cp, len);
      end
      // damage: overwrite, insert, or cut short
      if (pick < 28) begin
        pos = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
          0: text[pos] = 8'($urandom_range(0, 255));
          1: text.insert(pos, 8'($urandom_range(0, 255)));
          default: if (text.size() > 1) void'(text.pop_back());
        endcase
      end
    end
    foreach (text[i]) send_beat(text[i], i == text.size() - 1);
  endtask

  // main sequence
  initial begin
    int unsigned waited;
    bit          paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone continuation byte as lead
    send_beat(8'h80, 1'b1);
    // ascii extremes
    send_beat(8'h00, 1'b0); send_beat(8'h7F, 1'b1);
    // two and three byte forms
    send_beat(8'hC2, 1'b0); send_beat(8'hA9, 1'b1);
    send_beat(8'hE2, 1'b0); send_beat(8'h82, 1'b0); send_beat(8'hAC, 1'b1);
    // largest code point, a surrogate pair
    send_beat(8'hF4, 1'b0); send_beat(8'h8F, 1'b0);
    send_beat(8'hBF, 1'b0); send_beat(8'hBF, 1'b1);
    // just past the top, then a dropped byte closing the string
    send_beat(8'hF4, 1'b0); send_beat(8'h90, 1'b0);
    send_beat(8'h80, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'h41, 1'b1);
    // five-byte style lead
    send_beat(8'hFF, 1'b1);
    // bad trailing byte that also ends the string
    send_beat(8'hE2, 1'b0); send_beat(8'h41, 1'b1);
    // string cut short
    send_beat(8'hF0, 1'b0); send_beat(8'h9F, 1'b1);
    // lone surrogate value and overlong nul pass through
    send_beat(8'hED, 1'b0); send_beat(8'hA0, 1'b0); send_beat(8'h80, 1'b1);
    send_beat(8'hC0, 1'b0); send_beat(8'h80, 1'b1);
    drain_output();

    // random strings, with a stretch of no idling and one full drain
    while (beats_sent < 1550) begin
      calm = (beats_sent >= 500 && beats_sent < 800);
      if (!paused && beats_sent >= 1100) begin
        paused = 1'b1;
        drain_output();
      end
      send_random_string();
    end
    calm = 1'b0;

    // wait out the remaining units, then keep watching for strays
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (units.outstanding() != 0 && waited < 20000);
    repeat (8) @(posedge clk_i);
    units.flag_leftovers();
    if (units.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
